// ===== rtl/core/cbd_pkg.sv =====
// Package for the chunked body decoder: phase encoding, byte codes and the
// hex digit decode function. No dependencies.
`default_nettype none

package cbd_pkg;

  // Width of the size-line byte counter.
  localparam int unsigned LineW = 6;

  // Byte codes that end a size line.
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_SKIP1 = 3'd2,
    PH_SKIP2 = 3'd3,
    PH_END   = 3'd4,
    PH_FAULT = 3'd5
  } phase_e;

  // Decoded hex digit: valid flag and nibble value.
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Maps an ASCII byte to its hex digit value, if it is one.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] t;
    h = '0;
    t = '0;
    case (c) inside
      [8'h30:8'h39]: begin
        t = c - 8'h30;
        h = '{valid: 1'b1, value: t[3:0]};
      end
      [8'h61:8'h66]: begin
        t = c - 8'h57;
        h = '{valid: 1'b1, value: t[3:0]};
      end
      [8'h41:8'h46]: begin
        t = c - 8'h37;
        h = '{valid: 1'b1, value: t[3:0]};
      end
      default: begin
        h = '0;
      end
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbd_if.sv =====
// Valid/ready stream interfaces for the chunked body decoder: raw body bytes
// in and decoded payload results out. No dependencies.
`default_nettype none

interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_start;

  modport source (output valid, output body_byte, output body_start, input ready);
  modport sink   (input valid, input body_byte, input body_start, output ready);
endinterface

interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       end_seen;
  logic       format_error;

  modport source (output valid, output payload_byte, output end_seen,
                  output format_error, input ready);
  modport sink   (input valid, input payload_byte, input end_seen,
                  input format_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/chunked_body_decoder.sv =====
// Chunked transfer body decoder: top level with the parser state and the
// result register. Depends on cbd_pkg and the interfaces in cbd_if.sv.
//
// Usage: raw body bytes enter on in_i, one per transfer; body_start restarts
// the parser so that its byte is the first byte of a size line. Size-line
// bytes and the two bytes after each chunk's data give no result. Each data
// byte gives one result on out_o with both flags low. The LF that completes a
// zero-length size line gives one result with end_seen set, and a size line
// longer than LINE_LIMIT bytes or a length beyond COUNT_WIDTH bits gives one
// result with format_error set; after either, bytes are dropped until the
// next body_start.
// Results are registered: a result appears on out_o in the cycle after its byte's transfer.
// Throughput: one byte per cycle; the parser state update is a single pass of
// compare and shift logic between the state registers and the result register.
// When the receiver stalls, the result register holds and in_i.ready drops
// only while a held result is not being taken in the same cycle.
// Reset puts the parser at the start of a size line with an empty output.
`default_nettype none

module chunked_body_decoder #(
  parameter int unsigned LINE_LIMIT  = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  cbd_in_if.sink   in_i,
  cbd_out_if.source out_o
);

  localparam logic [cbd_pkg::LineW-1:0] LineLimit = LINE_LIMIT[cbd_pkg::LineW-1:0];

  // Parser state.
  cbd_pkg::phase_e          phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]   remaining_q, remaining_d;
  logic                     last_cr_q, last_cr_d;
  logic [cbd_pkg::LineW-1:0] line_len_q, line_len_d;
  logic                     digits_done_q, digits_done_d;

  // Result register.
  logic       out_valid_q;
  logic [7:0] payload_q;
  logic       end_q;
  logic       err_q;

  // Result of the current byte.
  logic       res_valid;
  logic [7:0] res_payload;
  logic       res_end;
  logic       res_err;

  // State seen by the current byte after an optional restart.
  cbd_pkg::phase_e           ph_eff;
  logic [COUNT_WIDTH-1:0]    rem_eff;
  logic                      cr_eff;
  logic [cbd_pkg::LineW-1:0] len_eff;
  logic                      dd_eff;
  cbd_pkg::hex_t             hex;
  logic                      in_xfer;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign hex        = cbd_pkg::hex_decode(in_i.body_byte);

  // Restart overrides the stored state for this byte.
  always_comb begin
    if (in_i.body_start) begin
      ph_eff  = cbd_pkg::PH_SIZE;
      rem_eff = '0;
      cr_eff  = 1'b0;
      len_eff = '0;
      dd_eff  = 1'b0;
    end else begin
      ph_eff  = phase_q;
      rem_eff = remaining_q;
      cr_eff  = last_cr_q;
      len_eff = line_len_q;
      dd_eff  = digits_done_q;
    end
  end

  // Next state and result for one byte.
  always_comb begin
    phase_d       = ph_eff;
    remaining_d   = rem_eff;
    last_cr_d     = cr_eff;
    line_len_d    = len_eff;
    digits_done_d = dd_eff;
    res_valid     = 1'b0;
    res_payload   = '0;
    res_end       = 1'b0;
    res_err       = 1'b0;
    case (ph_eff)
      cbd_pkg::PH_SIZE: begin
        if (len_eff >= LineLimit) begin
          phase_d   = cbd_pkg::PH_FAULT;
          res_valid = 1'b1;
          res_err   = 1'b1;
        end else begin
          line_len_d = len_eff + 1'b1;
          if (in_i.body_byte == cbd_pkg::CharLf && cr_eff) begin
            if (rem_eff == '0) begin
              phase_d   = cbd_pkg::PH_END;
              res_valid = 1'b1;
              res_end   = 1'b1;
            end else begin
              phase_d       = cbd_pkg::PH_DATA;
              last_cr_d     = 1'b0;
              line_len_d    = '0;
              digits_done_d = 1'b0;
            end
          end else begin
            last_cr_d = (in_i.body_byte == cbd_pkg::CharCr);
            if (!dd_eff) begin
              if (!hex.valid) begin
                digits_done_d = 1'b1;
              end else if (rem_eff[COUNT_WIDTH-1 -: 4] != 4'd0) begin
                // The shift would carry digits past the counter width.
                phase_d   = cbd_pkg::PH_FAULT;
                res_valid = 1'b1;
                res_err   = 1'b1;
                last_cr_d = cr_eff;
              end else begin
                remaining_d = {rem_eff[COUNT_WIDTH-5:0], hex.value};
              end
            end
          end
        end
      end
      cbd_pkg::PH_DATA: begin
        remaining_d = rem_eff - 1'b1;
        if (rem_eff == COUNT_WIDTH'(1)) begin
          phase_d = cbd_pkg::PH_SKIP1;
        end
        res_valid   = 1'b1;
        res_payload = in_i.body_byte;
      end
      cbd_pkg::PH_SKIP1: begin
        phase_d = cbd_pkg::PH_SKIP2;
      end
      cbd_pkg::PH_SKIP2: begin
        phase_d       = cbd_pkg::PH_SIZE;
        remaining_d   = '0;
        last_cr_d     = 1'b0;
        line_len_d    = '0;
        digits_done_d = 1'b0;
      end
      default: begin
        phase_d = ph_eff;
      end
    endcase
  end

  // Parser state registers advance on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= cbd_pkg::PH_SIZE;
      remaining_q   <= '0;
      last_cr_q     <= 1'b0;
      line_len_q    <= '0;
      digits_done_q <= 1'b0;
    end else if (in_xfer) begin
      phase_q       <= phase_d;
      remaining_q   <= remaining_d;
      last_cr_q     <= last_cr_d;
      line_len_q    <= line_len_d;
      digits_done_q <= digits_done_d;
    end
  end

  // Result register: loaded on an input transfer, emptied on an output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      payload_q <= res_payload;
      end_q     <= res_end;
      err_q     <= res_err;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.payload_byte = payload_q;
  assign out_o.end_seen     = end_q;
  assign out_o.format_error = err_q;

  // A result never carries both flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(end_q && err_q))
    else $error("end and error flags both set");

  // The data phase always owes at least one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cbd_pkg::PH_DATA |-> remaining_q != '0)
    else $error("data phase with zero bytes remaining");

  // The size-line counter never passes the line limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cbd_pkg::PH_SIZE |-> line_len_q <= LineLimit)
    else $error("size line counter beyond limit");

  // A held result is never overwritten by a new input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_xfer)
    else $error("input transfer while result stalled");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for chunked_body_decoder: streams chunked bodies and
// damaged ones through the block and checks every payload result against a
// built-in predictor. Depends on cbd_pkg, cbd_if.sv and the decoder RTL.
`default_nettype none

module tb;

  localparam int unsigned LineLimit  = 32;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned StallLimit = 1000;

  // One result as it leaves the decoder.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_seen;
    logic       format_error;
  } payload_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cbd_in_if  in_if ();
  cbd_out_if out_if ();

  chunked_body_decoder #(
    .LINE_LIMIT (LineLimit),
    .COUNT_WIDTH(CountWidth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser state as the predictor sees it.
  cbd_pkg::phase_e       cur_phase   = cbd_pkg::PH_SIZE;
  logic [CountWidth-1:0] remaining   = '0;
  logic                  saw_cr      = 1'b0;
  logic [5:0]            line_len    = '0;
  logic                  digits_done = 1'b0;

  payload_result_t payload_q[$];

  bit          start_next;
  bit          gaps_on;
  int unsigned bytes_sent;
  int unsigned bytes_ignored;
  int unsigned results_checked;
  int unsigned ends_checked;
  int unsigned faults_checked;
  int unsigned error_count;
  int unsigned stall_cycles;

  // Returns the value of an ASCII hex digit, or -1 for any other byte.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  function automatic void clear_line();
    remaining   = '0;
    saw_cr      = 1'b0;
    line_len    = '0;
    digits_done = 1'b0;
  endfunction

  // Advances the predicted parser by one body byte; returns 1 when the byte
  // gives a result, which is then placed in res.
  function automatic bit decode_step(input logic [7:0] c, input logic start,
                                     output payload_result_t res);
    int                    nib;
    logic [CountWidth+3:0] grown;
    res = '0;
    if (start) begin
      cur_phase = cbd_pkg::PH_SIZE;
      clear_line();
    end
    case (cur_phase)
      cbd_pkg::PH_SIZE: begin
        if (line_len >= LineLimit) begin
          cur_phase = cbd_pkg::PH_FAULT;
          res.format_error = 1'b1;
          return 1'b1;
        end
        line_len = line_len + 6'd1;
        // CR LF closes the line; a zero length marks the last chunk.
        if (c == cbd_pkg::CharLf && saw_cr) begin
          if (remaining == '0) begin
            cur_phase = cbd_pkg::PH_END;
            res.end_seen = 1'b1;
            return 1'b1;
          end
          cur_phase   = cbd_pkg::PH_DATA;
          saw_cr      = 1'b0;
          line_len    = '0;
          digits_done = 1'b0;
          return 1'b0;
        end
        // Leading hex digits build the length; the first other byte ends them.
        if (!digits_done) begin
          nib = hex_nibble(c);
          if (nib < 0) begin
            digits_done = 1'b1;
          end else begin
            grown = {remaining, 4'(nib)};
            if (grown[CountWidth+3:CountWidth] != 4'h0) begin
              cur_phase = cbd_pkg::PH_FAULT;
              res.format_error = 1'b1;
              return 1'b1;
            end
            remaining = grown[CountWidth-1:0];
          end
        end
        saw_cr = (c == cbd_pkg::CharCr);
        return 1'b0;
      end
      cbd_pkg::PH_DATA: begin
        remaining = remaining - 1'b1;
        if (remaining == '0) cur_phase = cbd_pkg::PH_SKIP1;
        res.payload_byte = c;
        return 1'b1;
      end
      cbd_pkg::PH_SKIP1: begin
        cur_phase = cbd_pkg::PH_SKIP2;
        return 1'b0;
      end
      cbd_pkg::PH_SKIP2: begin
        cur_phase = cbd_pkg::PH_SIZE;
        clear_line();
        return 1'b0;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Offers one body byte and waits for its transfer. The restart flag rides
  // on the first byte after start_next is set.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 13) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.body_byte  <= b;
    in_if.body_start <= start_next;
    start_next = 1'b0;
    bytes_sent++;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // A byte sent after the body has ended; the decoder drops it.
  task automatic send_ignored(input logic [7:0] b);
    send_byte(b);
    bytes_ignored++;
  endtask

  // Sends a size line: optional leading zeros, the length in hex with mixed
  // case, an optional extension of ext_len bytes, then CR LF.
  task automatic send_size_line(input int unsigned len, input int unsigned zeros,
                                input int unsigned ext_len);
    int unsigned nd;
    nd = 1;
    while (nd < 8 && (len >> (4 * nd)) != 0) nd++;
    repeat (zeros) send_byte("0");
    for (int i = int'(nd) - 1; i >= 0; i--) begin
      send_byte(hex_char(4'(len >> (4 * i)), 1'($urandom_range(0, 1))));
    end
    if (ext_len != 0) begin
      send_byte(";");
      repeat (ext_len - 1) send_byte(8'($urandom_range(32, 126)));
    end
    send_byte(cbd_pkg::CharCr);
    send_byte(cbd_pkg::CharLf);
  endtask

  // Extension, zero and all-ones payload, then an empty size line as the end.
  task automatic test_basic_chunk();
    start_next = 1'b1;
    send_byte("2");
    send_byte(";");
    send_byte(cbd_pkg::CharCr);
    send_byte(cbd_pkg::CharLf);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cbd_pkg::CharCr);
    send_byte(cbd_pkg::CharLf);
    send_byte(cbd_pkg::CharCr);
    send_byte(cbd_pkg::CharLf);
    send_ignored("A");
  endtask

  // Eight digits fill the counter exactly; the ninth overflows it.
  task automatic test_length_overflow();
    start_next = 1'b1;
    repeat (4) begin
      send_byte("f");
      send_byte("F");
    end
    send_byte("f");
    send_ignored(cbd_pkg::CharCr);
  endtask

  // A size line one byte longer than the line store holds.
  task automatic test_long_size_line();
    start_next = 1'b1;
    send_byte("1");
    repeat (LineLimit) send_byte("z");
    send_ignored(cbd_pkg::CharLf);
  endtask

  // Complete bodies with random chunk sizes, extensions and payload.
  task automatic test_wellformed_bodies(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned len;
    stop_at = bytes_sent - bytes_ignored + n_bytes;
    while (bytes_sent - bytes_ignored < stop_at) begin
      start_next = 1'b1;
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
        send_size_line(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                       ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0);
        repeat (len) send_byte(8'($urandom));
        // The two bytes after the data are not checked by the decoder.
        if ($urandom_range(0, 3) == 0) begin
          send_byte(8'($urandom));
          send_byte(8'($urandom));
        end else begin
          send_byte(cbd_pkg::CharCr);
          send_byte(cbd_pkg::CharLf);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        send_byte(cbd_pkg::CharCr);
        send_byte(cbd_pkg::CharLf);
      end else begin
        send_size_line(0, $urandom_range(0, 2),
                       ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
      end
      repeat ($urandom_range(0, 2)) send_ignored(8'($urandom));
    end
  endtask

  // Damaged bodies: overlong lines, too many digits, noise, and restarts in
  // the middle of a chunk.
  task automatic test_broken_bodies(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned len;
    logic [7:0]  b;
    stop_at = bytes_sent - bytes_ignored + n_bytes;
    while (bytes_sent - bytes_ignored < stop_at) begin
      start_next = 1'b1;
      case ($urandom_range(0, 3))
        0: begin
          // Padding from g to z never reads as a hex digit.
          send_byte(hex_char(4'($urandom_range(1, 15)), 1'b1));
          repeat ($urandom_range(LineLimit - 5, LineLimit + 2)) begin
            send_byte(8'($urandom_range(8'h67, 8'h7A)));
          end
          send_byte(cbd_pkg::CharCr);
          send_byte(cbd_pkg::CharLf);
        end
        1: begin
          send_byte(hex_char(4'($urandom_range(1, 15)), 1'b0));
          repeat ($urandom_range(7, 10)) begin
            send_byte(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
          end
          send_byte(cbd_pkg::CharCr);
          send_byte(cbd_pkg::CharLf);
        end
        2: begin
          repeat ($urandom_range(4, 30)) begin
            case ($urandom_range(0, 4))
              0: b = cbd_pkg::CharCr;
              1: b = cbd_pkg::CharLf;
              2: b = hex_char(4'($urandom), 1'($urandom_range(0, 1)));
              default: b = 8'($urandom);
            endcase
            if ($urandom_range(0, 15) == 0) start_next = 1'b1;
            send_byte(b);
          end
        end
        default: begin
          len = $urandom_range(4, 20);
          send_size_line(len, 0, 0);
          repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom));
        end
      endcase
    end
  endtask

  // Receiver side: ready drops at random while gaps are enabled.
  always @(negedge clk_i) begin
    out_if.ready <= !gaps_on || ($urandom_range(0, 99) >= 13);
  end

  // Predicts on each input transfer, checks each output transfer, and ends
  // the run if nothing moves for too long.
  always @(posedge clk_i) begin
    payload_result_t pred;
    payload_result_t want;
    payload_result_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        if (decode_step(in_if.body_byte, in_if.body_start, pred)) payload_q.push_back(pred);
      end
      if (out_if.valid && out_if.ready) begin
        got = '{payload_byte: out_if.payload_byte, end_seen: out_if.end_seen,
                format_error: out_if.format_error};
        if (payload_q.size() == 0) begin
          $error("unexpected result: payload_byte %0h end_seen %0b format_error %0b",
                 got.payload_byte, got.end_seen, got.format_error);
          error_count++;
        end else begin
          want = payload_q.pop_front();
          results_checked++;
          if (want.end_seen) ends_checked++;
          if (want.format_error) faults_checked++;
          if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
            error_count++;
          end
          if (got.end_seen !== want.end_seen) begin
            $error("end_seen: expected %0b, got %0b", want.end_seen, got.end_seen);
            error_count++;
          end
          if (got.format_error !== want.format_error) begin
            $error("format_error: expected %0b, got %0b", want.format_error,
                   got.format_error);
            error_count++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("tb: timeout with %0d results outstanding", payload_q.size());
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.body_byte  = '0;
    in_if.body_start = 1'b0;
    rst_ni           = 1'b0;
    start_next       = 1'b0;
    gaps_on          = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_chunk();
    test_length_overflow();
    test_long_size_line();
    test_wellformed_bodies(700);
    test_broken_bodies(250);
    // A stretch with both sides running flat out.
    gaps_on = 1'b0;
    test_wellformed_bodies(300);
    gaps_on = 1'b1;
    test_broken_bodies(150);
    test_wellformed_bodies(600);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (payload_q.size() != 0) @(posedge clk_i);
    // Let any stray result show up before closing.
    repeat (4) @(posedge clk_i);

    $display("tb: sent %0d body bytes (%0d after the end or an error)", bytes_sent,
             bytes_ignored);
    $display("tb: checked %0d results, %0d end flags and %0d format errors",
             results_checked, ends_checked, faults_checked);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== chunked_body_decoder.f =====
rtl/core/cbd_pkg.sv
rtl/core/cbd_if.sv
rtl/core/chunked_body_decoder.sv
tb/tb.sv
